@@ rtl/core/sqsnd_pkg.sv @@
// ----------------------------------------------------------------------------
// sqsnd_pkg
// shared types, register map and helper functions of the two-channel
// square-wave sound unit
// ----------------------------------------------------------------------------
package sqsnd_pkg;

    localparam int WAVE_BYTES = 16;
    localparam int WAVE_AW    = $clog2(WAVE_BYTES);
    localparam int NREGS      = 12;

    // request codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // result kinds
    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // sound register file slots
    localparam logic [3:0] R_NR10 = 4'd0;
    localparam logic [3:0] R_NR11 = 4'd1;
    localparam logic [3:0] R_NR12 = 4'd2;
    localparam logic [3:0] R_NR13 = 4'd3;
    localparam logic [3:0] R_NR14 = 4'd4;
    localparam logic [3:0] R_NR21 = 4'd5;
    localparam logic [3:0] R_NR22 = 4'd6;
    localparam logic [3:0] R_NR23 = 4'd7;
    localparam logic [3:0] R_NR24 = 4'd8;
    localparam logic [3:0] R_NR50 = 4'd9;
    localparam logic [3:0] R_NR51 = 4'd10;
    localparam logic [3:0] R_NR52 = 4'd11;

    // bus addresses
    localparam logic [15:0] A_NR10 = 16'hFF10;
    localparam logic [15:0] A_NR11 = 16'hFF11;
    localparam logic [15:0] A_NR12 = 16'hFF12;
    localparam logic [15:0] A_NR13 = 16'hFF13;
    localparam logic [15:0] A_NR14 = 16'hFF14;
    localparam logic [15:0] A_NR21 = 16'hFF16;
    localparam logic [15:0] A_NR22 = 16'hFF17;
    localparam logic [15:0] A_NR23 = 16'hFF18;
    localparam logic [15:0] A_NR24 = 16'hFF19;
    localparam logic [15:0] A_NR50 = 16'hFF24;
    localparam logic [15:0] A_NR51 = 16'hFF25;
    localparam logic [15:0] A_NR52 = 16'hFF26;
    localparam logic [15:0] A_WAVE = 16'hFF30;

    localparam logic [7:0] MASK_NR10 = 8'h80;
    localparam logic [7:0] MASK_LEN  = 8'h3F;
    localparam logic [7:0] MASK_HI   = 8'hBF;
    localparam logic [7:0] MASK_NR52 = 8'h70;

    localparam logic [7:0]  SAMPLE_PERIOD_RST = 8'd95;
    localparam logic [6:0]  AMP_STEP          = 7'd100;
    localparam logic [6:0]  LEN_FULL          = 7'd64;
    localparam logic [11:0] FREQ_TOP          = 12'd2048;

    // 8-step duty patterns, bit i is step i
    localparam logic [3:0][7:0] DUTY_WAVE = {
        8'b0111_1110,
        8'b1110_0001,
        8'b1000_0001,
        8'b1000_0000
    };

    typedef struct packed {
        logic       tick;
        logic       len_step;
        logic       clear;
        logic       len_wr;
        logic       hi_wr;
        logic [7:0] data;
    } sqsnd_chan_ctl_t;

    typedef struct packed {
        logic [7:0] len_reg;
        logic [7:0] env_reg;
        logic [7:0] lo_reg;
        logic [7:0] hi_reg;
    } sqsnd_chan_regs_t;

    function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] row;
        row = DUTY_WAVE[sel];
        return row[pos];
    endfunction

    // (2048 - freq) * 4, freq from 3 high bits and the low byte
    function automatic logic [13:0] period_reload(input logic [2:0] hi, input logic [7:0] lo);
        logic [11:0] diff;
        diff = FREQ_TOP - {1'b0, hi, lo};
        return {diff, 2'b00};
    endfunction

endpackage

@@ rtl/core/sqsnd_regs.sv @@
// ----------------------------------------------------------------------------
// sqsnd_regs
// sound register file and wave store, with masked bus read
// ----------------------------------------------------------------------------
module sqsnd_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic                        clear,
    input  logic [15:0]                 addr,
    input  logic [7:0]                  wdata,
    output logic [7:0]                  rdata,
    output sqsnd_pkg::sqsnd_chan_regs_t ch1_regs,
    output sqsnd_pkg::sqsnd_chan_regs_t ch2_regs
);

    logic [sqsnd_pkg::NREGS-1:0][7:0]      sound_reg;
    logic [sqsnd_pkg::NREGS-1:0][7:0]      sound_next;
    logic [sqsnd_pkg::WAVE_BYTES-1:0][7:0] wave_reg;
    logic [sqsnd_pkg::WAVE_BYTES-1:0][7:0] wave_next;
    logic                                  wave_hit;
    logic [sqsnd_pkg::WAVE_AW-1:0]         wave_idx;

    assign wave_hit = (addr[15:sqsnd_pkg::WAVE_AW]
                       == sqsnd_pkg::A_WAVE[15:sqsnd_pkg::WAVE_AW]);
    assign wave_idx = addr[sqsnd_pkg::WAVE_AW-1:0];

    always_comb
    begin
        sound_next = sound_reg;
        wave_next  = wave_reg;
        if (wr_en)
        begin
            if (clear)
            begin
                sound_next = '0;
                wave_next  = '0;
            end
            else if (wave_hit)
            begin
                wave_next[wave_idx] = wdata;
            end
            else
            begin
                case (addr)
                    sqsnd_pkg::A_NR10: sound_next[sqsnd_pkg::R_NR10] = wdata;
                    sqsnd_pkg::A_NR11: sound_next[sqsnd_pkg::R_NR11] = wdata;
                    sqsnd_pkg::A_NR12: sound_next[sqsnd_pkg::R_NR12] = wdata;
                    sqsnd_pkg::A_NR13: sound_next[sqsnd_pkg::R_NR13] = wdata;
                    sqsnd_pkg::A_NR14: sound_next[sqsnd_pkg::R_NR14] = wdata;
                    sqsnd_pkg::A_NR21: sound_next[sqsnd_pkg::R_NR21] = wdata;
                    sqsnd_pkg::A_NR22: sound_next[sqsnd_pkg::R_NR22] = wdata;
                    sqsnd_pkg::A_NR23: sound_next[sqsnd_pkg::R_NR23] = wdata;
                    sqsnd_pkg::A_NR24: sound_next[sqsnd_pkg::R_NR24] = wdata;
                    sqsnd_pkg::A_NR50: sound_next[sqsnd_pkg::R_NR50] = wdata;
                    sqsnd_pkg::A_NR51: sound_next[sqsnd_pkg::R_NR51] = wdata;
                    sqsnd_pkg::A_NR52: sound_next[sqsnd_pkg::R_NR52] = {wdata[7], 7'd0};
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_reg <= '0;
            wave_reg  <= '0;
        end
        else
        begin
            sound_reg <= sound_next;
            wave_reg  <= wave_next;
        end
    end

    always_comb
    begin
        if (wave_hit)
        begin
            rdata = wave_reg[wave_idx];
        end
        else
        begin
            case (addr)
                sqsnd_pkg::A_NR10: rdata = sound_reg[sqsnd_pkg::R_NR10] | sqsnd_pkg::MASK_NR10;
                sqsnd_pkg::A_NR11: rdata = sound_reg[sqsnd_pkg::R_NR11] | sqsnd_pkg::MASK_LEN;
                sqsnd_pkg::A_NR12: rdata = sound_reg[sqsnd_pkg::R_NR12];
                sqsnd_pkg::A_NR13: rdata = 8'hFF;
                sqsnd_pkg::A_NR14: rdata = sound_reg[sqsnd_pkg::R_NR14] | sqsnd_pkg::MASK_HI;
                sqsnd_pkg::A_NR21: rdata = sound_reg[sqsnd_pkg::R_NR21] | sqsnd_pkg::MASK_LEN;
                sqsnd_pkg::A_NR22: rdata = sound_reg[sqsnd_pkg::R_NR22];
                sqsnd_pkg::A_NR23: rdata = 8'hFF;
                sqsnd_pkg::A_NR24: rdata = sound_reg[sqsnd_pkg::R_NR24] | sqsnd_pkg::MASK_HI;
                sqsnd_pkg::A_NR50: rdata = sound_reg[sqsnd_pkg::R_NR50];
                sqsnd_pkg::A_NR51: rdata = sound_reg[sqsnd_pkg::R_NR51];
                sqsnd_pkg::A_NR52: rdata = sound_reg[sqsnd_pkg::R_NR52] | sqsnd_pkg::MASK_NR52;
                default:           rdata = 8'd0;
            endcase
        end
    end

    assign ch1_regs = '{len_reg: sound_reg[sqsnd_pkg::R_NR11],
                        env_reg: sound_reg[sqsnd_pkg::R_NR12],
                        lo_reg:  sound_reg[sqsnd_pkg::R_NR13],
                        hi_reg:  sound_reg[sqsnd_pkg::R_NR14]};
    assign ch2_regs = '{len_reg: sound_reg[sqsnd_pkg::R_NR21],
                        env_reg: sound_reg[sqsnd_pkg::R_NR22],
                        lo_reg:  sound_reg[sqsnd_pkg::R_NR23],
                        hi_reg:  sound_reg[sqsnd_pkg::R_NR24]};

endmodule

@@ rtl/core/sqsnd_chan.sv @@
// ----------------------------------------------------------------------------
// sqsnd_chan
// one square-wave channel: length counter, period timer, duty position
// ----------------------------------------------------------------------------
module sqsnd_chan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sqsnd_pkg::sqsnd_chan_ctl_t  ctl,
    input  sqsnd_pkg::sqsnd_chan_regs_t regs,
    output logic [3:0]                  level
);

    logic        on_reg,     on_next;
    logic [13:0] timer_reg,  timer_next;
    logic [3:0]  vol_reg,    vol_next;
    logic [1:0]  sel_reg,    sel_next;
    logic [2:0]  pos_reg,    pos_next;
    logic [6:0]  length_reg, length_next;
    logic        len_on_reg, len_on_next;

    always_comb
    begin
        on_next     = on_reg;
        timer_next  = timer_reg;
        vol_next    = vol_reg;
        sel_next    = sel_reg;
        pos_next    = pos_reg;
        length_next = length_reg;
        len_on_next = len_on_reg;
        if (ctl.clear)
        begin
            on_next     = 1'b0;
            timer_next  = '0;
            vol_next    = '0;
            sel_next    = '0;
            pos_next    = '0;
            length_next = '0;
            len_on_next = 1'b0;
        end
        else
        begin
            if (ctl.len_wr)
            begin
                length_next = sqsnd_pkg::LEN_FULL - {1'b0, ctl.data[5:0]};
            end
            if (ctl.hi_wr)
            begin
                len_on_next = ctl.data[6];
                // trigger, reload uses the byte being written
                if (ctl.data[7])
                begin
                    on_next    = 1'b1;
                    timer_next = sqsnd_pkg::period_reload(ctl.data[2:0], regs.lo_reg);
                    vol_next   = regs.env_reg[7:4];
                    sel_next   = regs.len_reg[7:6];
                    if (length_reg == 7'd0)
                    begin
                        length_next = sqsnd_pkg::LEN_FULL;
                    end
                end
            end
            if (ctl.tick)
            begin
                if (ctl.len_step && len_on_reg && (length_reg != 7'd0))
                begin
                    length_next = length_reg - 7'd1;
                    if (length_reg == 7'd1)
                    begin
                        on_next = 1'b0;
                    end
                end
                if (on_next)
                begin
                    if (timer_reg != 14'd0)
                    begin
                        timer_next = timer_reg - 14'd1;
                    end
                    else
                    begin
                        timer_next = sqsnd_pkg::period_reload(regs.hi_reg[2:0], regs.lo_reg);
                        pos_next   = pos_reg + 3'd1;
                    end
                end
            end
        end
    end

    // amplitude seen after this tick's update
    assign level = (on_next && sqsnd_pkg::duty_bit(sel_reg, pos_next)) ? vol_reg : 4'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg     <= 1'b0;
            timer_reg  <= '0;
            vol_reg    <= '0;
            sel_reg    <= '0;
            pos_reg    <= '0;
            length_reg <= '0;
            len_on_reg <= 1'b0;
        end
        else
        begin
            on_reg     <= on_next;
            timer_reg  <= timer_next;
            vol_reg    <= vol_next;
            sel_reg    <= sel_next;
            pos_reg    <= pos_next;
            length_reg <= length_next;
            len_on_reg <= len_on_next;
        end
    end

endmodule

@@ rtl/core/two_square_channel_sound_unit.sv @@
// ----------------------------------------------------------------------------
// two_square_channel_sound_unit
// two square-wave channels behind 8-bit bus registers, with frame sequencer
// and periodic summed sample output
//
//   channel   handshake              fields                       direction
//   request   in_valid/in_ready      op, address, write_data      in
//   result    out_valid/out_ready    kind, read_data, sample      out
//   config    cfg_we                 cfg_wdata (sample period)    in
//
// a request is taken into an input register at its accepting edge and is
// executed from there; its result (if any) is written to the output register
// when it executes. one request per cycle sustained while no request stalls.
// a request stalls in the input register only while it has a result and the
// output register is full and not being drained.
// reset clears all sound state; the sample period resets to 95.
// ----------------------------------------------------------------------------
module two_square_channel_sound_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  read_data,
    output logic [11:0] sample,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    logic        req_valid_reg;
    logic [1:0]  req_op_reg;
    logic [15:0] req_addr_reg;
    logic [7:0]  req_data_reg;

    logic        out_valid_reg;
    logic        kind_reg;
    logic [7:0]  read_data_reg;
    logic [11:0] sample_reg;

    logic [7:0]  period_reg;
    logic [15:0] frame_reg,  frame_next;
    logic [7:0]  scount_reg, scount_next;

    logic        is_tick, is_read, is_write;
    logic        req_fire, out_free, has_result;
    logic        clear;
    logic        len_step;
    logic [15:0] frame_inc;
    logic [7:0]  scount_inc;
    logic        sample_due;
    logic [7:0]  bus_rdata;
    logic [3:0]  lvl1, lvl2;
    logic [11:0] amp_sum;

    sqsnd_pkg::sqsnd_chan_regs_t ch1_regs, ch2_regs;
    sqsnd_pkg::sqsnd_chan_ctl_t  ch1_ctl,  ch2_ctl;

    assign is_tick  = req_valid_reg && (req_op_reg == sqsnd_pkg::OP_TICK);
    assign is_read  = req_valid_reg && (req_op_reg == sqsnd_pkg::OP_READ);
    assign is_write = req_valid_reg && (req_op_reg == sqsnd_pkg::OP_WRITE);

    assign frame_inc  = frame_reg + 16'd1;
    assign len_step   = (frame_inc[13:0] == 14'd0);
    assign scount_inc = scount_reg + 8'd1;
    assign sample_due = (scount_inc >= period_reg);

    assign has_result = is_read || (is_tick && sample_due);
    assign out_free   = !out_valid_reg || out_ready;
    assign req_fire   = req_valid_reg && (!has_result || out_free);
    assign in_ready   = !req_valid_reg || req_fire;

    assign clear = is_write && req_fire && (req_addr_reg == sqsnd_pkg::A_NR52)
                   && !req_data_reg[7];

    assign ch1_ctl = '{tick:     is_tick && req_fire,
                       len_step: len_step,
                       clear:    clear,
                       len_wr:   is_write && req_fire && (req_addr_reg == sqsnd_pkg::A_NR11),
                       hi_wr:    is_write && req_fire && (req_addr_reg == sqsnd_pkg::A_NR14),
                       data:     req_data_reg};
    assign ch2_ctl = '{tick:     is_tick && req_fire,
                       len_step: len_step,
                       clear:    clear,
                       len_wr:   is_write && req_fire && (req_addr_reg == sqsnd_pkg::A_NR21),
                       hi_wr:    is_write && req_fire && (req_addr_reg == sqsnd_pkg::A_NR24),
                       data:     req_data_reg};

    sqsnd_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (is_write && req_fire),
        .clear    (clear),
        .addr     (req_addr_reg),
        .wdata    (req_data_reg),
        .rdata    (bus_rdata),
        .ch1_regs (ch1_regs),
        .ch2_regs (ch2_regs)
    );

    sqsnd_chan u_ch1 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ch1_ctl),
        .regs  (ch1_regs),
        .level (lvl1)
    );

    sqsnd_chan u_ch2 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ch2_ctl),
        .regs  (ch2_regs),
        .level (lvl2)
    );

    assign amp_sum = 12'(lvl1) * 12'(sqsnd_pkg::AMP_STEP)
                   + 12'(lvl2) * 12'(sqsnd_pkg::AMP_STEP);

    always_comb
    begin
        frame_next  = frame_reg;
        scount_next = scount_reg;
        if (clear)
        begin
            frame_next = '0;
        end
        if (is_tick && req_fire)
        begin
            frame_next  = frame_inc;
            scount_next = sample_due ? 8'd0 : scount_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            period_reg    <= sqsnd_pkg::SAMPLE_PERIOD_RST;
            frame_reg     <= '0;
            scount_reg    <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                req_valid_reg <= in_valid;
            end
            if (req_fire && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
            frame_reg  <= frame_next;
            scount_reg <= scount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_op_reg   <= op;
            req_addr_reg <= address;
            req_data_reg <= write_data;
        end
        if (req_fire && has_result)
        begin
            kind_reg      <= is_read ? sqsnd_pkg::KIND_READ : sqsnd_pkg::KIND_SAMPLE;
            read_data_reg <= is_read ? bus_rdata : 8'd0;
            sample_reg    <= is_read ? 12'd0 : amp_sum;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign read_data = read_data_reg;
    assign sample    = sample_reg;

endmodule
